// ----- hdl/ifr_pkg.sv -----
// ----------------------------------------------------------------------------
// ifr_pkg
// Shared types and constants of the image fragment reassembler: header
// positions, status and decision codes, and the per-byte result record.
// ----------------------------------------------------------------------------
package ifr_pkg;

   localparam int LEN_POS           = 2;
   localparam int LINE_NUM_POS      = 3;
   localparam int SECTION_NUM_POS   = 4;
   localparam int LINE_TOTAL_POS    = 5;
   localparam int SECTION_TOTAL_POS = 6;
   localparam int PAYLOAD_BASE      = 7;
   localparam int LEN_OFFSET        = 3;
   localparam int IMAGE_BYTES       = 65536;
   localparam int POS_MAX           = 511;
   localparam int QUEUE_DEPTH       = 4;

   localparam int HDR_LEN     = 0;
   localparam int HDR_LINE    = 1;
   localparam int HDR_SECTION = 2;
   localparam int HDR_LTOTAL  = 3;
   localparam int HDR_STOTAL  = 4;
   localparam int HDR_COUNT   = 5;

   function automatic int max_of(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   localparam int DECIDE_POS = max_of(max_of(max_of(LEN_POS, LINE_NUM_POS),
                                             max_of(SECTION_NUM_POS, LINE_TOTAL_POS)),
                                      SECTION_TOTAL_POS);

   typedef enum logic [1:0] {
      DEC_NONE    = 2'd0,
      DEC_ACCEPT  = 2'd1,
      DEC_REJECT  = 2'd2,
      DEC_RESTART = 2'd3
   } decision_type;

   typedef enum logic [1:0] {
      ST_PARTIAL  = 2'd0,
      ST_COMPLETE = 2'd1,
      ST_REJECTED = 2'd2,
      ST_RESTART  = 2'd3
   } status_type;

   typedef enum logic {
      KIND_WRITE  = 1'b0,
      KIND_REPORT = 1'b1
   } kind_type;

   typedef struct packed {
      logic        wr_valid;
      logic [15:0] wr_address;
      logic [7:0]  wr_data;
      logic        rpt_valid;
      status_type  status;
      logic        image_start;
      logic        idle_ready;
   } rec_type;

endpackage

// ----- hdl/ifr_front.sv -----
// ----------------------------------------------------------------------------
// ifr_front
// Accepts frame bytes, captures header fields, judges frame order and
// builds one result record per byte.
// ----------------------------------------------------------------------------
module ifr_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      frame_byte,
   input  logic            frame_end,
   input  logic [4:0]      type_bytes,
   output logic            rec_push,
   output ifr_pkg::rec_type rec
);
   import ifr_pkg::*;

   logic [7:0]   line_ff, line_in;
   logic [7:0]   section_ff, section_in;
   logic         err_ff, err_in;
   logic [16:0]  idx_ff, idx_in;
   logic [8:0]   pos_ff, pos_in;
   decision_type dec_ff, dec_in;
   logic [7:0]   hdr_ff [HDR_COUNT];
   logic [7:0]   hdr_in [HDR_COUNT];

   logic         match, first, final_frag, restarted, payload_ok;
   logic [7:0]   line_base, section_base;
   logic [9:0]   pos_ext, start_pos, stop_pos;

   always_comb begin
      hdr_in = hdr_ff;
      if (pos_ff == 9'(LEN_POS))           hdr_in[HDR_LEN]     = frame_byte;
      if (pos_ff == 9'(LINE_NUM_POS))      hdr_in[HDR_LINE]    = frame_byte;
      if (pos_ff == 9'(SECTION_NUM_POS))   hdr_in[HDR_SECTION] = frame_byte;
      if (pos_ff == 9'(LINE_TOTAL_POS))    hdr_in[HDR_LTOTAL]  = frame_byte;
      if (pos_ff == 9'(SECTION_TOTAL_POS)) hdr_in[HDR_STOTAL]  = frame_byte;

      match      = (hdr_in[HDR_LINE] == line_ff) && (hdr_in[HDR_SECTION] == section_ff);
      first      = (hdr_in[HDR_LINE] == 8'd1) && (hdr_in[HDR_SECTION] == 8'd1);
      final_frag = (hdr_in[HDR_LINE] == hdr_in[HDR_LTOTAL]) &&
                   (hdr_in[HDR_SECTION] == hdr_in[HDR_STOTAL]);
      restarted  = !match;
      line_base    = restarted ? 8'd1 : line_ff;
      section_base = restarted ? 8'd1 : section_ff;

      line_in    = line_ff;
      section_in = section_ff;
      err_in     = err_ff;
      idx_in     = idx_ff;
      dec_in     = dec_ff;
      pos_in     = pos_ff;

      // judge the frame once its header is complete
      if (dec_ff == DEC_NONE && pos_ff == 9'(DECIDE_POS)) begin
         if (!match && !first) begin
            err_in = 1'b1;
            dec_in = DEC_REJECT;
         end else begin
            err_in = 1'b0;
            if (first) idx_in = '0;
            if (final_frag) begin
               line_in    = 8'd1;
               section_in = 8'd1;
            end else if (hdr_in[HDR_STOTAL] == hdr_in[HDR_SECTION]) begin
               section_in = 8'd1;
               line_in    = line_base + 8'd1;
            end else begin
               line_in    = line_base;
               section_in = section_base + 8'd1;
            end
            dec_in = restarted ? DEC_RESTART : DEC_ACCEPT;
         end
      end

      pos_ext    = {1'b0, pos_ff};
      start_pos  = 10'(PAYLOAD_BASE) + {5'b0, type_bytes} + 10'd1;
      stop_pos   = {2'b0, hdr_in[HDR_LEN]} + 10'(LEN_OFFSET);
      payload_ok = (dec_in == DEC_ACCEPT || dec_in == DEC_RESTART) &&
                   (pos_ff > 9'(DECIDE_POS)) && (pos_ext >= start_pos) &&
                   (pos_ext <= stop_pos) && ({4'b0, idx_in} < 21'(IMAGE_BYTES));

      rec            = '0;
      rec.wr_valid   = payload_ok;
      rec.wr_address = idx_in[15:0];
      rec.wr_data    = frame_byte;
      if (payload_ok) idx_in = idx_in + 17'd1;

      if (frame_end) begin
         rec.rpt_valid = 1'b1;
         if (dec_in == DEC_ACCEPT || dec_in == DEC_RESTART) begin
            rec.image_start = first;
            if (dec_in == DEC_RESTART)
               rec.status = ST_RESTART;
            else
               rec.status = final_frag ? ST_COMPLETE : ST_PARTIAL;
            if (final_frag) idx_in = '0;
         end else begin
            rec.status = ST_REJECTED;
            err_in     = 1'b1;
         end
         rec.idle_ready = (line_in == 8'd1) && (section_in == 8'd1) && !err_in;
         pos_in = '0;
         dec_in = DEC_NONE;
      end else begin
         pos_in = (pos_ff < 9'(POS_MAX)) ? pos_ff + 9'd1 : pos_ff;
      end

      rec_push = accept && (rec.wr_valid || rec.rpt_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff    <= 8'd1;
         section_ff <= 8'd1;
         err_ff     <= 1'b0;
         idx_ff     <= '0;
         pos_ff     <= '0;
         dec_ff     <= DEC_NONE;
      end else if (accept) begin
         line_ff    <= line_in;
         section_ff <= section_in;
         err_ff     <= err_in;
         idx_ff     <= idx_in;
         pos_ff     <= pos_in;
         dec_ff     <= dec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hdr_ff <= hdr_in;
      end
   end

endmodule

// ----- hdl/ifr_queue.sv -----
// ----------------------------------------------------------------------------
// ifr_queue
// Register queue of result records between the front and back parts.
// ----------------------------------------------------------------------------
module ifr_queue #(
   parameter int DEPTH = ifr_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ifr_pkg::rec_type push_rec,
   input  logic             deq,
   output ifr_pkg::rec_type head,
   output logic             empty,
   output logic             full
);
   import ifr_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rec_type         slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign empty   = (count_ff == CW'(0));
   assign full    = (count_ff == CW'(DEPTH));
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = deq && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      if (do_push && !do_pop)
         count_in = count_ff + CW'(1);
      else if (do_pop && !do_push)
         count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

// ----- hdl/ifr_back.sv -----
// ----------------------------------------------------------------------------
// ifr_back
// Splits each queued record into its payload write and status report
// and presents them one at a time on the result ports.
// ----------------------------------------------------------------------------
module ifr_back (
   input  logic             clock,
   input  logic             reset,
   input  ifr_pkg::rec_type head,
   input  logic             q_empty,
   output logic             deq,
   input  logic             pop,
   output logic             empty,
   output logic             rsp_kind,
   output logic [15:0]      rsp_write_address,
   output logic [7:0]       rsp_write_data,
   output logic [1:0]       rsp_status,
   output logic             rsp_image_start,
   output logic             rsp_idle_ready,
   output logic             rsp_last
);
   import ifr_pkg::*;

   logic phase_ff, phase_in;
   logic show_write, taken;

   always_comb begin
      show_write = head.wr_valid && !phase_ff;
      rsp_last   = !(show_write && head.rpt_valid);
      empty      = q_empty;
      taken      = pop && !q_empty;
      deq        = taken && rsp_last;
      phase_in   = taken ? !rsp_last : phase_ff;

      if (show_write) begin
         rsp_kind          = KIND_WRITE;
         rsp_write_address = head.wr_address;
         rsp_write_data    = head.wr_data;
         rsp_status        = ST_PARTIAL;
         rsp_image_start   = 1'b0;
         rsp_idle_ready    = 1'b0;
      end else begin
         rsp_kind          = KIND_REPORT;
         rsp_write_address = '0;
         rsp_write_data    = '0;
         rsp_status        = head.status;
         rsp_image_start   = head.image_start;
         rsp_idle_ready    = head.idle_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

// ----- hdl/image_fragment_reassembler_unit.sv -----
// ----------------------------------------------------------------------------
// image_fragment_reassembler_unit
// A result is queued and shows on the result ports at the queue head. One byte
// per cycle while the queue is not full; a frame's last byte that also writes
// payload pops as a write and a report, absorbed by a queue of QUEUE_DEPTH
// entries. Reset (synchronous): clears counters, order flag, write index, byte
// position, queue and type_bytes; header bytes are captured per frame.
// ----------------------------------------------------------------------------
module image_fragment_reassembler_unit #(
   parameter int QUEUE_DEPTH = ifr_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_frame_end,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_kind,
   output logic [15:0] rsp_write_address,
   output logic [7:0]  rsp_write_data,
   output logic [1:0]  rsp_status,
   output logic        rsp_image_start,
   output logic        rsp_idle_ready,
   output logic        rsp_last,
   input  logic        valid,
   output logic        ready,
   input  logic [4:0]  csr_type_bytes
);
   import ifr_pkg::*;

   logic [4:0] type_bytes_ff;
   logic       accept, rec_push, q_empty, deq;
   rec_type    rec, head;

   assign ready  = 1'b1;
   assign accept = push && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         type_bytes_ff <= '0;
      end else if (valid && ready) begin
         type_bytes_ff <= csr_type_bytes;
      end
   end

   ifr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .frame_byte (req_frame_byte),
      .frame_end  (req_frame_end),
      .type_bytes (type_bytes_ff),
      .rec_push   (rec_push),
      .rec        (rec)
   );

   ifr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rec_push),
      .push_rec (rec),
      .deq      (deq),
      .head     (head),
      .empty    (q_empty),
      .full     (full)
   );

   ifr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .q_empty           (q_empty),
      .deq               (deq),
      .pop               (pop),
      .empty             (empty),
      .rsp_kind          (rsp_kind),
      .rsp_write_address (rsp_write_address),
      .rsp_write_data    (rsp_write_data),
      .rsp_status        (rsp_status),
      .rsp_image_start   (rsp_image_start),
      .rsp_idle_ready    (rsp_idle_ready),
      .rsp_last          (rsp_last)
   );

   a_report_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind == KIND_REPORT) |-> rsp_last)
      else $error("status report not marked last");

   a_write_clean: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind == KIND_WRITE) |->
         (rsp_status == ST_PARTIAL && !rsp_image_start && !rsp_idle_ready))
      else $error("payload write carries report fields");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queue not empty after reset");

endmodule
